[rtl/bmma_pkg.sv]
// shared types, constants and register codes for the battery moving-average monitor
`default_nettype none

package bmma_pkg;

  // window length and derived widths
  localparam int WINDOW_LEN = 8;
  localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int MV_W       = 16;
  localparam int SUM_W      = 22;

  // floor reciprocal of the window length, scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = SUM_W;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << RECIP_SHIFT) / WINDOW_LEN);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR = 1'b0,
    CFG_OK_THR  = 1'b1
  } cfg_reg_t;

  localparam logic [MV_W-1:0] LOW_THR_RST = 16'd3300;
  localparam logic [MV_W-1:0] OK_THR_RST  = 16'd3700;

  // input item
  typedef struct packed {
    logic [MV_W-1:0] sample_mv;
    logic            charger_present;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [MV_W-1:0] average_mv;
    logic            charging_now;
    logic            chg_rise;
    logic            chg_fall;
    logic            volt_low;
    logic            volt_ok;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/bmma_ram.sv]
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module bmma_ram #(
  parameter  int WIDTH  = 16,
  parameter  int DEPTH  = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [ADDR_W-1:0]       wr_addr,
  input  wire logic [WIDTH-1:0]        wr_data,
  input  wire logic                    rd_en,
  input  wire logic [ADDR_W-1:0]       rd_addr,
  output logic      [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/battery_monitor_moving_average.sv]
// top level: boxcar moving average of battery samples with charger and threshold flags
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | in_valid, in_stall, in_item            | in
//  result   | out_valid, out_stall, out_item         | out
//  config   | cfg_wr_en, cfg_index, cfg_wdata        | in
//
// one item per cycle sustained while out_stall does not freeze the pipe; each taken
// item passes through ring read, running-sum update and ring write-back, reciprocal
// multiply, then correction and threshold compare into the output register.
// the ring lives in a ram with registered read.
// rst_n is synchronous; it clears control state, the ring reads as zero until filled,
// and in_stall stays high while it is asserted.
// out_stall with a result waiting freezes the whole pipe and raises in_stall.
`default_nettype none

module battery_monitor_moving_average
  import bmma_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // pipeline enable and handshake
  logic en;
  logic acc;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || !rst_n;
  assign acc      = in_valid && !in_stall;

  // configuration registers
  logic [MV_W-1:0] low_thr_r;
  logic [MV_W-1:0] ok_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r <= LOW_THR_RST;
      ok_thr_r  <= OK_THR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOW_THR: low_thr_r <= cfg_wdata[MV_W-1:0];
        CFG_OK_THR:  ok_thr_r  <= cfg_wdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: ring read, write pointer and charger edge detection
  logic [PTR_W-1:0] pos_r, pos_nxt;
  logic             chg_r;
  logic             s1_v_r;
  logic [MV_W-1:0]  s1_sample_r;
  logic [PTR_W-1:0] s1_pos_r;
  logic             s1_now_r, s1_conn_r, s1_disc_r;

  assign pos_nxt = (pos_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      chg_r  <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
      if (acc) begin
        pos_r <= pos_nxt;
        chg_r <= in_item.charger_present;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sample_r <= in_item.sample_mv;
      s1_pos_r    <= pos_r;
      s1_now_r    <= in_item.charger_present;
      s1_conn_r   <= in_item.charger_present && !chg_r;
      s1_disc_r   <= !in_item.charger_present && chg_r;
    end
  end

  // ring storage
  logic            ram_we;
  logic [MV_W-1:0] ram_rd;

  assign ram_we = en && s1_v_r;

  bmma_ram #(
    .WIDTH (MV_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_pos_r),
    .wr_data (s1_sample_r),
    .rd_en   (acc),
    .rd_addr (pos_r),
    .rd_data (ram_rd)
  );

  // stage 1: running sum update, ring write-back, fill tracking
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             filled_r;
  logic             use_mean;
  logic [MV_W-1:0]  old_mv;
  logic             s2_v_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic             s2_mean_r;
  logic [MV_W-1:0]  s2_sample_r;
  logic             s2_now_r, s2_conn_r, s2_disc_r;

  // entries not yet written read as zero until the ring has filled once
  assign old_mv   = filled_r ? ram_rd : '0;
  assign sum_nxt  = sum_r - SUM_W'(old_mv) + SUM_W'(s1_sample_r);
  assign use_mean = filled_r || (s1_pos_r == PTR_W'(WINDOW_LEN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      filled_r <= 1'b0;
      s2_v_r   <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        sum_r    <= sum_nxt;
        filled_r <= use_mean;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      s2_sum_r    <= sum_nxt;
      s2_mean_r   <= use_mean;
      s2_sample_r <= s1_sample_r;
      s2_now_r    <= s1_now_r;
      s2_conn_r   <= s1_conn_r;
      s2_disc_r   <= s1_disc_r;
    end
  end

  // stage 2: quotient estimate by reciprocal multiply, low by at most one
  logic [2*SUM_W-1:0] recip_prod;
  logic               s3_v_r;
  logic [MV_W-1:0]    s3_q0_r;
  logic [SUM_W-1:0]   s3_sum_r;
  logic               s3_mean_r;
  logic [MV_W-1:0]    s3_sample_r;
  logic               s3_now_r, s3_conn_r, s3_disc_r;

  assign recip_prod = (2*SUM_W)'(s2_sum_r) * (2*SUM_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_v_r) begin
      s3_q0_r     <= recip_prod[RECIP_SHIFT +: MV_W];
      s3_sum_r    <= s2_sum_r;
      s3_mean_r   <= s2_mean_r;
      s3_sample_r <= s2_sample_r;
      s3_now_r    <= s2_now_r;
      s3_conn_r   <= s2_conn_r;
      s3_disc_r   <= s2_disc_r;
    end
  end

  // stage 3: quotient correction, average select and threshold compare
  logic [SUM_W:0]  q_times_n;
  logic [SUM_W:0]  rem;
  logic [MV_W-1:0] quot;
  logic [MV_W-1:0] avg;
  logic            is_low;
  out_item_t       out_item_nxt;
  logic            out_valid_r;

  assign q_times_n = (SUM_W+1)'(s3_q0_r) * (SUM_W+1)'(WINDOW_LEN);
  assign rem       = {1'b0, s3_sum_r} - q_times_n;
  assign quot      = (rem >= (SUM_W+1)'(WINDOW_LEN)) ? s3_q0_r + 1'b1 : s3_q0_r;
  assign avg       = s3_mean_r ? quot : s3_sample_r;
  assign is_low    = (avg <= low_thr_r);

  always_comb begin
    out_item_nxt.average_mv   = avg;
    out_item_nxt.charging_now = s3_now_r;
    out_item_nxt.chg_rise     = s3_conn_r;
    out_item_nxt.chg_fall     = s3_disc_r;
    out_item_nxt.volt_low     = is_low;
    out_item_nxt.volt_ok      = !is_low && (avg >= ok_thr_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_v_r) begin
      out_item <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[tb/battery_monitor_moving_average_test.sv]
// self-checking testbench for the battery moving-average monitor with random flow control
`timescale 1ns / 1ps

module battery_monitor_moving_average_test;
  import bmma_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  battery_monitor_moving_average uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the averaging state and thresholds
  logic [MV_W-1:0]  ring_model [WINDOW_LEN];
  logic [SUM_W-1:0] sum_model;
  int unsigned      slot_model;
  logic             filled_model;
  logic             charging_model;
  logic [MV_W-1:0]  low_thr_model = LOW_THR_RST;
  logic [MV_W-1:0]  ok_thr_model  = OK_THR_RST;

  in_item_t  pending_samples[$];
  out_item_t expected_readings[$];

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  bit   hold_req       = 1'b0;
  int   mismatches     = 0;
  int   results_checked = 0;
  int   items_accepted = 0;
  int   cfg_writes     = 0;
  logic chg_level      = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("[battery_monitor_moving_average] ERROR");
    $finish;
  end

  // advance the shadow state by one sample and return the reading it should produce
  function automatic out_item_t predict_reading(in_item_t it);
    out_item_t       r;
    logic [MV_W-1:0] avg;
    int unsigned     pos;
    pos = slot_model;
    sum_model = sum_model - SUM_W'(ring_model[pos]) + SUM_W'(it.sample_mv);
    ring_model[pos] = it.sample_mv;
    if (pos == WINDOW_LEN - 1) filled_model = 1'b1;
    avg = filled_model ? MV_W'(sum_model / WINDOW_LEN) : it.sample_mv;
    slot_model = (pos + 1) % WINDOW_LEN;
    r.average_mv   = avg;
    r.charging_now = it.charger_present;
    r.chg_rise     = it.charger_present & ~charging_model;
    r.chg_fall     = ~it.charger_present & charging_model;
    r.volt_low     = (avg <= low_thr_model);
    r.volt_ok      = !r.volt_low && (avg >= ok_thr_model);
    charging_model = it.charger_present;
    return r;
  endfunction

  // mostly near the thresholds so averages cross them, plus full range and extremes
  function automatic logic [MV_W-1:0] pick_sample();
    int unsigned sel;
    int          v;
    sel = $urandom_range(99);
    if (sel < 10) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    if (sel < 40) return MV_W'($urandom);
    v = (sel < 70) ? int'(low_thr_model) : int'(ok_thr_model);
    v = v + int'($urandom_range(600)) - 300;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return MV_W'(v);
  endfunction

  task automatic queue_item(logic [MV_W-1:0] mv, logic chg);
    in_item_t it;
    it.sample_mv       = mv;
    it.charger_present = chg;
    pending_samples.push_back(it);
  endtask

  // random samples with the charger bit in runs
  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) chg_level = ~chg_level;
      queue_item(pick_sample(), chg_level);
    end
  endtask

  // wait until every item is taken and every reading has come back,
  // checked mid-cycle so the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(cfg_reg_t idx, logic [MV_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_LOW_THR) low_thr_model = val;
    else ok_thr_model = val;
    cfg_writes++;
  endtask

  task automatic set_thresholds(logic [MV_W-1:0] low_mv, logic [MV_W-1:0] ok_mv);
    write_threshold(CFG_LOW_THR, low_mv);
    write_threshold(CFG_OK_THR, ok_mv);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // input driver: presents queued items, predicts each one as it is taken
  always @(posedge clk) begin
    logic     valid_next;
    in_item_t item_next;
    valid_next = in_valid;
    item_next  = in_item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(in_item));
        items_accepted++;
        valid_next = 1'b0;
      end
      if (!valid_next && pending_samples.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        item_next  = pending_samples.pop_front();
        valid_next = 1'b1;
      end
    end
    in_valid <= valid_next;
    in_item  <= item_next;
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    out_item_t want;
    logic      stall_next;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: average_mv %0d", out_item.average_mv);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        compare_field("average_mv", want.average_mv, out_item.average_mv);
        compare_field("charging_now", want.charging_now, out_item.charging_now);
        compare_field("chg_rise", want.chg_rise, out_item.chg_rise);
        compare_field("chg_fall", want.chg_fall, out_item.chg_fall);
        compare_field("volt_low", want.volt_low, out_item.volt_low);
        compare_field("volt_ok", want.volt_ok, out_item.volt_ok);
        results_checked++;
      end
    end
    // long hold-off so the pipe backs up into the input
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else begin
      stall_next = ($urandom_range(99) < recv_stall_pct);
    end
    out_stall <= stall_next;
  end

  // stimulus sequence
  initial begin
    logic [MV_W-1:0] a;
    logic [MV_W-1:0] b;
    for (int i = 0; i < WINDOW_LEN; i++) ring_model[i] = '0;
    sum_model      = '0;
    slot_model     = 0;
    filled_model   = 1'b0;
    charging_model = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: threshold edges and extremes before the ring fills, charger edges
    queue_item(16'd0, 1'b0);
    queue_item(16'hFFFF, 1'b1);
    queue_item(16'd3300, 1'b1);
    queue_item(16'd3301, 1'b0);
    queue_item(16'd3699, 1'b0);
    queue_item(16'd3700, 1'b1);
    queue_item(16'h8000, 1'b1);
    // this one fills the ring, first mean reported
    queue_item(16'h7FFF, 1'b0);
    // all-ones window drives the mean to its maximum, then back to zero
    for (int i = 0; i < 8; i++) queue_item(16'hFFFF, i[0]);
    for (int i = 0; i < 8; i++) queue_item(16'd0, i[1]);
    wait_idle();

    // random phases over threshold settings and flow-control modes
    for (int p = 0; p < 8; p++) begin
      case (p)
        1: set_thresholds(16'd0, 16'hFFFF);
        2: set_thresholds(16'hFFFF, 16'd0);
        3: set_thresholds(16'd0, 16'd0);
        4: set_thresholds(16'hFFFF, 16'hFFFF);
        5: begin
          a = MV_W'($urandom_range(4000, 1000));
          set_thresholds(a, a + MV_W'($urandom_range(800)));
        end
        6: begin
          a = MV_W'($urandom_range(4000, 1000));
          set_thresholds(a, a);
        end
        7: begin
          // crossed: ok below low, low takes priority
          b = MV_W'($urandom_range(4000, 1000));
          set_thresholds(b + MV_W'($urandom_range(800, 1)), b);
        end
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      queue_random(75);
      if (p == 0) hold_req = 1'b1;
      // sender pauses mid-phase until the pipe has drained
      if (p == 3) wait_idle();
      queue_random(75);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d samples and %0d readings over %0d threshold writes,",
             items_accepted, results_checked, cfg_writes);
    $display("ring fill, charger edges, crossed and extreme thresholds, stalls and gaps");
    if (mismatches == 0) begin
      $display("[battery_monitor_moving_average] OK");
    end else begin
      $display("[battery_monitor_moving_average] ERROR");
    end
    $finish;
  end

endmodule
